// ===== rtl/spal_pkg.sv =====
// Shared types, constants and helper functions for the sample pair to ASCII line block.
// No dependencies; imported by every module of the block.
package spal_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DIGIT_COUNT     = 5;
  localparam int BCD_BITS        = 4 * DIGIT_COUNT;
  localparam int LINE_LEN        = 2 * DIGIT_COUNT + 2;
  localparam int IDX_BITS        = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_COMMA   = 8'd44;
  localparam logic [7:0] ASCII_NEWLINE = 8'd10;

  localparam logic [IDX_BITS-1:0] COMMA_IDX = IDX_BITS'(DIGIT_COUNT);
  localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(LINE_LEN - 1);

  typedef struct packed {
    logic [BCD_BITS-1:0] x;
    logic [BCD_BITS-1:0] y;
  } bcd_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One double-dabble step: add 3 to every digit >= 5, then shift in one bit.
  function automatic logic [BCD_BITS-1:0] dabble_step(logic [BCD_BITS-1:0] b, logic in_bit);
    logic [BCD_BITS-1:0] adj;
    adj = b;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (b[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = b[4*k +: 4] + 4'd3;
      end
    end
    return {adj[BCD_BITS-2:0], in_bit};
  endfunction

  // ASCII digit at position pos, most significant digit at position 0.
  function automatic logic [7:0] digit_char(logic [BCD_BITS-1:0] b, logic [IDX_BITS-1:0] pos);
    logic [BCD_BITS-1:0] sh;
    sh = b >> (4 * (DIGIT_COUNT - 1 - int'(pos)));
    return ASCII_ZERO + {4'd0, sh[3:0]};
  endfunction

  function automatic logic [7:0] line_char(bcd_pair_t p, logic [IDX_BITS-1:0] idx);
    logic [7:0] ch;
    if (idx < COMMA_IDX) begin
      ch = digit_char(p.x, idx);
    end else if (idx == COMMA_IDX) begin
      ch = ASCII_COMMA;
    end else if (idx < LAST_IDX) begin
      ch = digit_char(p.y, idx - COMMA_IDX - IDX_BITS'(1));
    end else begin
      ch = ASCII_NEWLINE;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/spal_front.sv =====
// Front end: converts both samples of a pair to BCD, one bit per cycle, with the last
// bit held while the queue is full. Needs spal_pkg; writes finished pairs to spal_queue.
module spal_front import spal_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic                   push,
  output logic                   full,
  input  q_status_t              q_stat,
  output logic                   enq,
  output bcd_pair_t              enq_data
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(SAMPLE_BITS - 1);

  logic                   busy;
  logic [CNT_BITS-1:0]    cnt;
  logic [SAMPLE_BITS-1:0] bin_x, bin_y;
  logic [BCD_BITS-1:0]    bcd_x, bcd_y;
  logic [BCD_BITS-1:0]    bcd_x_next, bcd_y_next;
  logic                   last, step_en, accept;

  assign last       = cnt == LAST_STEP;
  assign step_en    = busy && !(last && q_stat.full);
  assign full       = busy && (!last || q_stat.full);
  assign accept     = push && !full;
  assign bcd_x_next = dabble_step(bcd_x, bin_x[SAMPLE_BITS-1]);
  assign bcd_y_next = dabble_step(bcd_y, bin_y[SAMPLE_BITS-1]);

  // final step goes straight into the queue
  assign enq        = busy && last && !q_stat.full;
  assign enq_data.x = bcd_x_next;
  assign enq_data.y = bcd_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy  <= 1'b1;
      cnt   <= '0;
      bin_x <= x_sample;
      bin_y <= y_sample;
      bcd_x <= '0;
      bcd_y <= '0;
    end else if (step_en) begin
      bin_x <= {bin_x[SAMPLE_BITS-2:0], 1'b0};
      bin_y <= {bin_y[SAMPLE_BITS-2:0], 1'b0};
      bcd_x <= bcd_x_next;
      bcd_y <= bcd_y_next;
      cnt   <= cnt + CNT_BITS'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/spal_queue.sv =====
// Short register queue of BCD digit pairs between front and back end.
// Depends on spal_pkg.
module spal_queue import spal_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      enq,
  input  bcd_pair_t enq_data,
  input  logic      deq,
  output bcd_pair_t head,
  output q_status_t stat
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  bcd_pair_t           entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = count == CNT_FULL;
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        entries[wr_ptr] <= enq_data;
        wr_ptr          <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (enq && !deq) begin
        count <= count + CNT_BITS'(1);
      end else if (deq && !enq) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/spal_back.sv =====
// Back end: walks the 12 characters of a line from the queue head into an output register.
// Depends on spal_pkg; reads spal_queue.
module spal_back import spal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bcd_pair_t head,
  input  q_status_t q_stat,
  output logic      deq,
  output logic [7:0] out_char,
  output logic      line_end,
  output logic      empty,
  input  logic      pop
);

  logic                out_valid;
  logic [IDX_BITS-1:0] idx;
  logic                load;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign deq   = load && !q_stat.empty && (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      if (!q_stat.empty) begin
        out_valid <= 1'b1;
        out_char  <= line_char(head, idx);
        line_end  <= idx == LAST_IDX;
        idx       <= (idx == LAST_IDX) ? '0 : idx + IDX_BITS'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sample_pair_to_ascii_line_top.sv =====
// Sample pair to ASCII line: converts an (x, y) sample pair into "xxxxx,yyyyy\n".
// Depends on spal_pkg, spal_front, spal_queue and spal_back.
//
// Input side is a queue write port: x_sample/y_sample are taken when push is
// high and full is low. Output side is a queue read port: while empty is low,
// out_char holds the oldest character and line_end marks the newline; it is
// taken when pop is high.
// Each pair yields 12 characters: five zero-padded decimal digits of x, a
// comma, five digits of y, and a newline with line_end set.
// Pair rate is set by the binary to BCD converter (one bit per cycle, holding
// its last step while the queue is full) and by the serializer (one character
// per cycle while the receiver pops). A two-entry queue between them lets
// the converter work ahead while a line is going out.
// Reset clears all control state; the block comes up empty and not full.
// When the receiver stalls, the current character holds, the serializer and
// queue fill, and full stays high once the converter has nowhere to put its result.
module sample_pair_to_ascii_line_top import spal_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic                   push,
  output logic                   full,
  output logic [7:0]             out_char,
  output logic                   line_end,
  output logic                   empty,
  input  logic                   pop
);

  q_status_t q_stat;
  bcd_pair_t enq_data, head;
  logic      enq, deq;

  spal_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .x_sample (x_sample),
    .y_sample (y_sample),
    .push     (push),
    .full     (full),
    .q_stat   (q_stat),
    .enq      (enq),
    .enq_data (enq_data)
  );

  spal_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_data (enq_data),
    .deq      (deq),
    .head     (head),
    .stat     (q_stat)
  );

  spal_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .deq      (deq),
    .out_char (out_char),
    .line_end (line_end),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== rtl/spal_checker.sv =====
// Port-level checks for sample_pair_to_ascii_line_top, attached by bind.
// Depends on spal_pkg.
module spal_checker import spal_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic [7:0] out_char,
  input logic       line_end,
  input logic       empty,
  input logic       pop
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_newline: assert property (@(posedge clk) disable iff (rst)
    (!empty && line_end) |-> (out_char == ASCII_NEWLINE))
    else $error("line_end on a character other than newline");

  a_body_char: assert property (@(posedge clk) disable iff (rst)
    (!empty && !line_end) |->
      ((out_char >= ASCII_ZERO && out_char <= ASCII_ZERO + 8'd9) || out_char == ASCII_COMMA))
    else $error("line body holds a character other than digit or comma");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(line_end)))
    else $error("stalled result changed");

endmodule

bind sample_pair_to_ascii_line_top spal_checker u_spal_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .out_char (out_char),
  .line_end (line_end),
  .empty    (empty),
  .pop      (pop)
);
